// File: rtl/dqsl_pkg.sv
// Shared types and constants of the delta-coded sample log.
`timescale 1ns / 1ps

package dqsl_pkg;

  // Field widths
  localparam int VAL_W    = 20;  // Q12.8 reading
  localparam int DIFF_W   = 21;  // base minus sample
  localparam int CODE_W   = 8;   // stored delta code
  localparam int IDX_W    = 10;  // entry index and value count
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // Decode by 64/5: x/5 == (x * 52429) >> 18 for the magnitudes seen here
  localparam int                 RECIP_SHIFT = 18;
  localparam logic [16:0]        RECIP_FIFTH = 17'd52429;
  localparam int                 MAG_W       = 14;  // |code| * 64
  localparam int                 PROD_W      = 31;
  localparam int                 QMAG_W      = 11;  // |code| * 64 / 5

  // Saturation limits
  localparam logic signed [17:0]       CODE_HI = 18'sd127;
  localparam logic signed [17:0]       CODE_LO = -18'sd128;
  localparam logic signed [DIFF_W-1:0] VAL_HI  = 21'sd524287;
  localparam logic signed [DIFF_W-1:0] VAL_LO  = -21'sd524288;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Decoder stage A result, aligned with the second pipeline stage
  typedef struct packed {
    logic [QMAG_W-1:0] qmag;
    logic              inexact;
    logic              pos;
  } dec_part_t;

endpackage

// File: rtl/dqsl_delta_ram.sv
// Delta code memory: one write port, one registered read port with write bypass.
`timescale 1ns / 1ps

module dqsl_delta_ram #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [dqsl_pkg::CODE_W-1:0] wr_code,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [dqsl_pkg::CODE_W-1:0] rd_code
);
  import dqsl_pkg::*;

  logic [CODE_W-1:0] mem [DEPTH];

  // Write the code of the append leaving the first stage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_code;
    end
  end

  // Read under the pipeline enable; forward a write to the same slot
  always_ff @(posedge clk) begin
    if (en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_code <= wr_code;
      end else begin
        rd_code <= mem[rd_addr];
      end
    end
  end

endmodule

// File: rtl/dqsl_encoder.sv
// Encoder: turn base minus sample into a saturated 8-bit delta code.
`timescale 1ns / 1ps

module dqsl_encoder (
  input  logic signed [dqsl_pkg::DIFF_W-1:0] diff,
  output logic        [dqsl_pkg::CODE_W-1:0] code
);
  import dqsl_pkg::*;

  logic signed [23:0] dx;
  logic signed [23:0] p;
  logic signed [17:0] fl;
  logic               inexact;
  logic signed [17:0] t;

  // Scale by 20/256 as 5/64
  assign dx = {{3{diff[DIFF_W-1]}}, diff};
  assign p  = (dx <<< 2) + dx;

  // Floor by shift, then round toward zero for negative inexact values
  assign fl      = p[23:6];
  assign inexact = |p[5:0];
  assign t       = fl + {17'd0, p[23] & inexact};

  // Saturate to the code range
  always_comb begin
    if (t > CODE_HI) begin
      code = CODE_HI[CODE_W-1:0];
    end else if (t < CODE_LO) begin
      code = CODE_LO[CODE_W-1:0];
    end else begin
      code = t[CODE_W-1:0];
    end
  end

endmodule

// File: rtl/dqsl_decoder.sv
// Decoder: rebuild base - code*64/5 truncated toward zero, over two stages.
`timescale 1ns / 1ps

module dqsl_decoder (
  input  logic                              clk,
  input  logic                              en,
  input  logic        [dqsl_pkg::CODE_W-1:0] code,
  input  logic signed [dqsl_pkg::VAL_W-1:0]  base,
  output logic signed [dqsl_pkg::VAL_W-1:0]  value
);
  import dqsl_pkg::*;

  logic [CODE_W-1:0] mag;
  logic [MAG_W-1:0]  m;
  logic [PROD_W-1:0] prod;
  dec_part_t         part;

  logic signed [DIFF_W-1:0] bx;
  logic signed [DIFF_W-1:0] qx;
  logic signed [DIFF_W-1:0] s;
  logic signed [DIFF_W-1:0] s_adj;

  // Stage A: magnitude times 64, divide by 5 through the reciprocal
  assign mag  = code[CODE_W-1] ? (~code + 1'b1) : code;
  assign m    = {mag, 6'd0};
  assign prod = PROD_W'(m) * PROD_W'(RECIP_FIFTH);

  // Hold the quotient; a remainder leaves at least 1/5 in the fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      part.qmag    <= prod[RECIP_SHIFT+QMAG_W-1:RECIP_SHIFT];
      part.inexact <= |prod[RECIP_SHIFT-1:RECIP_SHIFT-3];
      part.pos     <= ~code[CODE_W-1];
    end
  end

  // Stage B: offset the base, fix truncation direction, saturate
  assign bx = {base[VAL_W-1], base};
  assign qx = {{(DIFF_W-QMAG_W){1'b0}}, part.qmag};
  assign s  = part.pos ? (bx - qx) : (bx + qx);

  always_comb begin
    if (part.pos && part.inexact && (s > 0)) begin
      s_adj = s - 1'b1;
    end else if (!part.pos && part.inexact && (s < 0)) begin
      s_adj = s + 1'b1;
    end else begin
      s_adj = s;
    end
  end

  always_comb begin
    if (s_adj > VAL_HI) begin
      value = VAL_HI[VAL_W-1:0];
    end else if (s_adj < VAL_LO) begin
      value = VAL_LO[VAL_W-1:0];
    end else begin
      value = s_adj[VAL_W-1:0];
    end
  end

endmodule

// File: rtl/delta_quantized_sample_log_unit.sv
// Top level of the delta-coded sample log: control, count and result pipeline.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   cfg      | cfg_valid, cfg_ready | base_value
//   in       | in_valid, in_stall   | op, sample_value, entry_index
//   out      | out_valid, out_stall | status, read_value, value_count
//
// One transaction enters per cycle while in_stall is low; its result passes
// the memory read and decoder multiply registers, then the decoder add and
// the output register. The delta memory (one write port, one read port) is
// read as a transaction enters and written from the stage 1 register; a read
// of the slot being written takes the bypassed code.
// rst is synchronous: the count and all valid flags clear, memory is left as is.
// A stalled output freezes the whole pipeline and raises in_stall.
`timescale 1ns / 1ps

module delta_quantized_sample_log_unit #(
  parameter int LOG_DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic signed [dqsl_pkg::VAL_W-1:0]     base_value,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [dqsl_pkg::OP_W-1:0]      op,
  input  logic signed [dqsl_pkg::VAL_W-1:0]     sample_value,
  input  logic        [dqsl_pkg::IDX_W-1:0]     entry_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic        [dqsl_pkg::STATUS_W-1:0]  status,
  output logic signed [dqsl_pkg::VAL_W-1:0]     read_value,
  output logic        [dqsl_pkg::IDX_W-1:0]     value_count
);
  import dqsl_pkg::*;

  localparam int ADDR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int CMP_W  = (CNT_W + 1 > IDX_W) ? CNT_W + 1 : IDX_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LOG_DEPTH);

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_BASE,
    SEL_DEC
  } sel_t;

  // Pipeline control
  logic en;
  logic accept;

  // Base register and entry count
  logic signed [VAL_W-1:0] base;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;

  // Entry decode
  status_e              acc_status;
  sel_t                 acc_sel;
  logic                 acc_wr;
  logic [CMP_W-1:0]     idx_ext;
  logic [CMP_W-1:0]     cnt_ext;
  logic [CMP_W-1:0]     idx_m1;
  logic [CMP_W-1:0]     cnt_out;
  logic [ADDR_W-1:0]    rd_addr;
  logic signed [DIFF_W-1:0] acc_diff;

  // Stage 1
  logic                     s1_valid;
  logic                     s1_wr;
  logic [ADDR_W-1:0]        s1_addr;
  logic signed [DIFF_W-1:0] s1_diff;
  status_e                  s1_status;
  sel_t                     s1_sel;
  logic [IDX_W-1:0]         s1_cnt;

  // Stage 2
  logic             s2_valid;
  status_e          s2_status;
  sel_t             s2_sel;
  logic [IDX_W-1:0] s2_cnt;

  // Memory and arithmetic
  logic                    wr_en;
  logic [CODE_W-1:0]       wr_code;
  logic [CODE_W-1:0]       rd_code;
  logic signed [VAL_W-1:0] dec_value;

  // Advance everything unless a finished result is held
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign accept    = in_valid && en;
  assign cfg_ready = 1'b1;

  // Capture the base register
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (cfg_valid) begin
      base <= base_value;
    end
  end

  // Decode the incoming transaction against the current count
  assign idx_ext  = CMP_W'(entry_index);
  assign cnt_ext  = CMP_W'(count);
  assign idx_m1   = idx_ext - 1'b1;
  assign rd_addr  = idx_m1[ADDR_W-1:0];
  assign cnt_out  = CMP_W'(count_next) + 1'b1;
  assign acc_diff = {base[VAL_W-1], base} - {sample_value[VAL_W-1], sample_value};

  always_comb begin
    acc_status = ST_OK;
    acc_sel    = SEL_ZERO;
    acc_wr     = 1'b0;
    count_next = count;
    unique case (op_e'(op))
      OP_APPEND: begin
        if (count >= DEPTH_C) begin
          acc_status = ST_FULL;
        end else begin
          acc_wr     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      OP_READ: begin
        if (idx_ext > cnt_ext) begin
          acc_status = ST_RANGE;
        end else if (entry_index == '0) begin
          acc_sel = SEL_BASE;
        end else begin
          acc_sel = SEL_DEC;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Update the count on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Stage 1: hold the transaction while its read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_wr     <= acc_wr;
      s1_addr   <= count[ADDR_W-1:0];
      s1_diff   <= acc_diff;
      s1_status <= acc_status;
      s1_sel    <= acc_sel;
      s1_cnt    <= cnt_out[IDX_W-1:0];
    end
  end

  // Encode and store the append code
  dqsl_encoder u_encoder (
    .diff (s1_diff),
    .code (wr_code)
  );

  assign wr_en = en && s1_valid && s1_wr;

  dqsl_delta_ram #(
    .DEPTH  (LOG_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .en      (en),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_code (wr_code),
    .rd_addr (rd_addr),
    .rd_code (rd_code)
  );

  dqsl_decoder u_decoder (
    .clk   (clk),
    .en    (en),
    .code  (rd_code),
    .base  (base),
    .value (dec_value)
  );

  // Stage 2: wait for the decoder quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_status <= s1_status;
      s2_sel    <= s1_sel;
      s2_cnt    <= s1_cnt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status      <= s2_status;
      value_count <= s2_cnt;
      case (s2_sel)
        SEL_BASE: read_value <= base;
        SEL_DEC:  read_value <= dec_value;
        default:  read_value <= '0;
      endcase
    end
  end

endmodule
